/* sv/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 3;

  // command codes
  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdDelete = 2'd1;
  localparam logic [CmdW-1:0] CmdList   = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StDone     = 3'd0;
  localparam logic [StatusW-1:0] StOverflow = 3'd1;
  localparam logic [StatusW-1:0] StEmpty    = 3'd2;
  localparam logic [StatusW-1:0] StNotFound = 3'd3;
  localparam logic [StatusW-1:0] StListed   = 3'd4;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                   ins;
    logic                   del;
    logic                   rot;
    logic signed [ValW-1:0] val;
  } cell_ctrl_t;

endpackage

/* sv/spq_cell.sv */
module spq_cell (
  input  logic                                clk_i,
  input  spq_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                occ_i,
  input  logic                                occ_next_i,
  input  logic                                left_t_i,
  input  logic                                left_found_i,
  input  logic signed [spq_pkg::ValW-1:0]     left_val_i,
  input  logic signed [spq_pkg::ValW-1:0]     right_val_i,
  input  logic signed [spq_pkg::ValW-1:0]     head_val_i,
  output logic                                t_o,
  output logic                                found_o,
  output logic signed [spq_pkg::ValW-1:0]     val_o
);

  logic signed [spq_pkg::ValW-1:0] val_q, val_d;
  logic                            eq;

  // insert point marker: set from the first cell not larger than the word on
  assign t_o     = !occ_i || (ctrl_i.val >= val_q);
  // first equal cell and everything after it closes up on delete
  assign eq      = occ_i && (val_q == ctrl_i.val);
  assign found_o = left_found_i || eq;
  assign val_o   = val_q;

  // next value from own word, left neighbor, right neighbor or head
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (left_t_i) begin
        val_d = left_val_i;
      end else if (t_o) begin
        val_d = ctrl_i.val;
      end
    end else if (ctrl_i.del) begin
      if (found_o) begin
        val_d = right_val_i;
      end
    end else if (ctrl_i.rot) begin
      if (occ_i && !occ_next_i) begin
        val_d = head_val_i;
      end else if (occ_i) begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* sv/sorted_priority_queue.sv */
// Insert and delete: the result word is registered and appears in the cycle after acceptance.
// List: on acceptance the block enters StList, which then registers one word per cycle while
// the receiver does not stall, count words in all; an empty list gives its one word in the
// next cycle. The head of the cell chain rotates so the order is restored when the last
// word leaves. A new command is taken once the previous one has produced all its words.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending word.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [spq_pkg::CmdW-1:0]               cmd_i,
  input  logic signed [spq_pkg::ValW-1:0]        value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [spq_pkg::StatusW-1:0]            status_o,
  output logic signed [spq_pkg::ValW-1:0]        entry_o,
  output logic                                   last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StList = 2'b10
  } state_e;

  state_e                            state_q, state_d;
  logic [CntW-1:0]                   count_q, count_d;
  logic [CntW-1:0]                   rem_q, rem_d;
  logic                              out_valid_q, out_valid_d;
  logic [spq_pkg::StatusW-1:0]       status_q, status_d;
  logic signed [spq_pkg::ValW-1:0]   entry_q, entry_d;
  logic                              last_q, last_d;

  spq_pkg::cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]                  occ, t, found;
  logic signed [spq_pkg::ValW-1:0]   vals [DEPTH];

  logic out_free, accept, full, is_ins, is_del, is_list;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign is_ins     = accept && (cmd_i == spq_pkg::CmdInsert);
  assign is_del     = accept && (cmd_i == spq_pkg::CmdDelete);
  assign is_list    = accept && (cmd_i == spq_pkg::CmdList);

  // cell control
  assign ctrl.ins = is_ins && !full;
  assign ctrl.del = is_del && found[DEPTH-1];
  assign ctrl.rot = (state_q == StList) && out_free;
  assign ctrl.val = value_i;

  // occupancy from the fill count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CntW'(i) < count_q);
    end
  end

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                            left_t, left_found, occ_next;
    logic signed [spq_pkg::ValW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_t     = 1'b0;
      assign left_found = 1'b0;
      assign left_val   = value_i;
    end else begin : g_mid
      assign left_t     = t[g-1];
      assign left_found = found[g-1];
      assign left_val   = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = vals[g];
      assign occ_next  = 1'b0;
    end else begin : g_inner
      assign right_val = vals[g+1];
      assign occ_next  = occ[g+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[g]),
      .occ_next_i   (occ_next),
      .left_t_i     (left_t),
      .left_found_i (left_found),
      .left_val_i   (left_val),
      .right_val_i  (right_val),
      .head_val_i   (vals[0]),
      .t_o          (t[g]),
      .found_o      (found[g]),
      .val_o        (vals[g])
    );
  end

  // command sequencing and result word
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    entry_d     = entry_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (is_ins) begin
          out_valid_d = 1'b1;
          status_d    = full ? spq_pkg::StOverflow : spq_pkg::StDone;
          entry_d     = '0;
          last_d      = 1'b1;
          if (!full) begin
            count_d = count_q + 1'b1;
          end
        end else if (is_del) begin
          out_valid_d = 1'b1;
          entry_d     = '0;
          last_d      = 1'b1;
          if (count_q == '0) begin
            status_d = spq_pkg::StEmpty;
          end else if (!found[DEPTH-1]) begin
            status_d = spq_pkg::StNotFound;
          end else begin
            status_d = spq_pkg::StDone;
            count_d  = count_q - 1'b1;
          end
        end else if (is_list) begin
          if (count_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = spq_pkg::StEmpty;
            entry_d     = '0;
            last_d      = 1'b1;
          end else begin
            rem_d   = count_q;
            state_d = StList;
          end
        end
      end
      StList: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = spq_pkg::StListed;
          entry_d     = vals[0];
          last_d      = (rem_q == CntW'(1));
          rem_d       = rem_q - 1'b1;
          if (rem_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign entry_o     = entry_q;
  assign last_o      = last_q;

endmodule

/* sv/spq_check.sv */
module spq_check (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [spq_pkg::CmdW-1:0]         cmd_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [spq_pkg::StatusW-1:0]      status_o,
  input logic signed [spq_pkg::ValW-1:0]  entry_o,
  input logic                             last_o
);

  // only listed words carry a stored value
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != spq_pkg::StListed) |-> (entry_o == '0))
    else $error("entry not zero on a status word");

  // every status word is the only word of its command
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != spq_pkg::StListed) |-> last_o)
    else $error("status word without last");

  // status stays within the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= spq_pkg::StListed))
    else $error("undefined status code");

  // insert and delete answer in the next cycle
  a_ins_del_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    ((cmd_i == spq_pkg::CmdInsert) || (cmd_i == spq_pkg::CmdDelete))
    |=> out_valid_o && last_o)
    else $error("insert or delete word missing");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(status_o) && $stable(entry_o) && $stable(last_o))
    else $error("stalled result word changed");

endmodule

bind sorted_priority_queue spq_check u_spq_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .entry_o     (entry_o),
  .last_o      (last_o)
);

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int unsigned QDepth    = 8;
  localparam int unsigned RandItems = 150;
  localparam int unsigned QuietTail = 30;
  localparam int unsigned DrainCyc  = 20;
  localparam int unsigned StuckMax  = 2000;

  // code the block has no use for
  localparam logic [spq_pkg::CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [spq_pkg::StatusW-1:0]     status;
    logic signed [spq_pkg::ValW-1:0] entry;
    logic                            last;
  } word_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [spq_pkg::CmdW-1:0]        cmd_i       = spq_pkg::CmdInsert;
  logic signed [spq_pkg::ValW-1:0] value_i     = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [spq_pkg::StatusW-1:0]     status_o;
  logic signed [spq_pkg::ValW-1:0] entry_o;
  logic                            last_o;

  // no idling on either side once set
  logic quiet = 1'b0;

  // sorted shadow of the queue and the words it must produce
  class spq_scoreboard;
    logic signed [spq_pkg::ValW-1:0] sorted_q[$];
    word_t                           words_due_q[$];
    int                              errors;

    function new();
      errors = 0;
    endfunction

    function void push_word(logic [spq_pkg::StatusW-1:0] status,
                            logic signed [spq_pkg::ValW-1:0] entry, logic last);
      word_t w;
      w.status = status;
      w.entry  = entry;
      w.last   = last;
      words_due_q.push_back(w);
    endfunction

    function int pending();
      return words_due_q.size();
    endfunction

    function logic signed [spq_pkg::ValW-1:0] pick_stored();
      return sorted_q[$urandom_range(0, sorted_q.size() - 1)];
    endfunction

    // update the shadow queue for one accepted command word
    function void note_word(logic [spq_pkg::CmdW-1:0] cmd,
                            logic signed [spq_pkg::ValW-1:0] val);
      int pos;
      pos = 0;
      case (cmd)
        spq_pkg::CmdInsert: begin
          if (sorted_q.size() >= QDepth) begin
            push_word(spq_pkg::StOverflow, '0, 1'b1);
          end else begin
            // goes ahead of the first value less than or equal to it
            while (pos < sorted_q.size() && val < sorted_q[pos]) pos++;
            sorted_q.insert(pos, val);
            push_word(spq_pkg::StDone, '0, 1'b1);
          end
        end
        spq_pkg::CmdDelete: begin
          if (sorted_q.size() == 0) begin
            push_word(spq_pkg::StEmpty, '0, 1'b1);
          end else begin
            while (pos < sorted_q.size() && sorted_q[pos] != val) pos++;
            if (pos == sorted_q.size()) begin
              push_word(spq_pkg::StNotFound, '0, 1'b1);
            end else begin
              sorted_q.delete(pos);
              push_word(spq_pkg::StDone, '0, 1'b1);
            end
          end
        end
        spq_pkg::CmdList: begin
          if (sorted_q.size() == 0) begin
            push_word(spq_pkg::StEmpty, '0, 1'b1);
          end else begin
            foreach (sorted_q[i]) begin
              push_word(spq_pkg::StListed, sorted_q[i], i == sorted_q.size() - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // compare one result word with the oldest one due
    function void check_word(logic [spq_pkg::StatusW-1:0] status,
                             logic signed [spq_pkg::ValW-1:0] entry, logic last);
      word_t w;
      if (words_due_q.size() == 0) begin
        $error("unexpected result word: status %0d entry %0d last %0d", status, entry, last);
        errors++;
      end else begin
        w = words_due_q.pop_front();
        if (status !== w.status) begin
          $error("status mismatch: expected %0d, actual %0d", w.status, status);
          errors++;
        end
        if (entry !== w.entry) begin
          $error("entry mismatch: expected %0d, actual %0d", w.entry, entry);
          errors++;
        end
        if (last !== w.last) begin
          $error("last mismatch: expected %0d, actual %0d", w.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  spq_scoreboard sb = new();

  sorted_priority_queue #(
    .DEPTH(QDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .entry_o    (entry_o),
    .last_o     (last_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // result words taken at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(status_o, entry_o, last_o);
  end

  // receiver stall in bursts
  initial begin : out_stall_gen
    int n;
    forever begin
      n = $urandom_range(1, 16);
      if (!quiet && $urandom_range(0, 2) == 0) out_stall_i <= 1'b1;
      else out_stall_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no word moving
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < StuckMax) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // one command word, at times with a random gap ahead of it
  task automatic send_word(input logic [spq_pkg::CmdW-1:0] cmd,
                           input logic signed [spq_pkg::ValW-1:0] val);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(cmd, val);
  endtask

  // hold the sender until every due word has come
  task automatic drain_wait();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic signed [spq_pkg::ValW-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      default: return int'($urandom_range(0, 20)) - 10;
    endcase
  endfunction

  // stimulus
  initial begin : main
    int n_words;
    int roll;
    logic signed [spq_pkg::ValW-1:0] v;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queue cases
    send_word(spq_pkg::CmdList, 32'sd77);
    send_word(spq_pkg::CmdDelete, 32'sd5);
    // extremes and duplicates
    send_word(spq_pkg::CmdInsert, '0);
    send_word(spq_pkg::CmdInsert, 32'sh7fff_ffff);
    send_word(spq_pkg::CmdInsert, 32'sh8000_0000);
    send_word(spq_pkg::CmdInsert, -32'sd1);
    send_word(spq_pkg::CmdInsert, '0);
    send_word(spq_pkg::CmdInsert, 32'sh7fff_ffff);
    send_word(spq_pkg::CmdList, '0);
    send_word(spq_pkg::CmdDelete, 32'sd12345);
    send_word(spq_pkg::CmdDelete, '0);
    send_word(CmdUnused, 32'sh5555_aaaa);
    // fill up, then overflow
    send_word(spq_pkg::CmdInsert, 32'sd5);
    send_word(spq_pkg::CmdInsert, 32'sd100);
    send_word(spq_pkg::CmdInsert, -32'sd100);
    send_word(spq_pkg::CmdInsert, 32'sd1);
    send_word(spq_pkg::CmdList, -32'sd1);
    send_word(spq_pkg::CmdDelete, 32'sh8000_0000);
    send_word(spq_pkg::CmdDelete, 32'sh7fff_ffff);
    send_word(CmdUnused, '0);
    send_word(spq_pkg::CmdList, '0);
    drain_wait();

    // random part: mostly inserts and deletes of stored values
    n_words = 0;
    while (n_words < RandItems) begin
      quiet = (n_words >= RandItems - QuietTail);
      if (!quiet && $urandom_range(0, 39) == 0) drain_wait();
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_word(spq_pkg::CmdInsert, rand_value());
        n_words++;
      end else if (roll < 80) begin
        if (sb.sorted_q.size() != 0 && $urandom_range(0, 3) != 0) v = sb.pick_stored();
        else v = rand_value();
        send_word(spq_pkg::CmdDelete, v);
        n_words++;
      end else if (roll < 95) begin
        send_word(spq_pkg::CmdList, $urandom);
        n_words++;
      end else begin
        send_word(CmdUnused, $urandom);
      end
    end

    // wind down
    drain_wait();
    repeat (DrainCyc) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sorted_priority_queue.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_check.sv
test/tb.sv
